// File: sv/queue_throughput_top_k_core_defines.svh
`ifndef QUEUE_THROUGHPUT_TOP_K_CORE_DEFINES_SVH
`define QUEUE_THROUGHPUT_TOP_K_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define QTK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define QTK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: sv/qtk_pkg.sv
package qtk_pkg;
  localparam int TOP_COUNT = 10;
  localparam int QUEUE_COUNT = 256;
  localparam int QIDX_W = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int SLOT_W = $clog2(TOP_COUNT + 1);
  localparam int DIV_STEPS = 67;
  localparam logic [31:0] RATE_MAX = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_DIV, ST_INSERT, ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic div_start;
    logic div_step;
    logic insert;
    logic emit_load;
    logic emit_adv;
    logic list_clear;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic emit_last;
    logic item_last;
  } stat_t;
endpackage

// File: sv/queue_throughput_top_k_core.sv
// Ranks queues by bytes sent per polling round and reports the top ten on each
// round end. After reset the per-queue byte store is cleared; no request is taken
// while it clears. Each request then passes through capture, store read,
// bit-serial rate division (67 quotient steps and one to finish), and parallel
// insertion. A round end adds ten result beats, one per cycle while out_ready
// is high, before the next request is taken.
module queue_throughput_top_k_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_queue_id,
  input  logic [63:0] in_sent_byte_total,
  input  logic [31:0] in_sent_packet_total,
  input  logic [31:0] in_elapsed_ms,
  input  logic        in_round_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_rank,
  output logic        out_slot_valid,
  output logic [7:0]  out_ranked_queue,
  output logic [63:0] out_byte_delta,
  output logic [31:0] out_packet_total_out,
  output logic [31:0] out_rate_kbps,
  output logic        out_last_of_run
);
  qtk_pkg::cmd_t  cmd;
  qtk_pkg::stat_t stat;

  qtk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  qtk_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_queue_id          (in_queue_id),
    .in_sent_byte_total   (in_sent_byte_total),
    .in_sent_packet_total (in_sent_packet_total),
    .in_elapsed_ms        (in_elapsed_ms),
    .in_round_end         (in_round_end),
    .out_rank             (out_rank),
    .out_slot_valid       (out_slot_valid),
    .out_ranked_queue     (out_ranked_queue),
    .out_byte_delta       (out_byte_delta),
    .out_packet_total_out (out_packet_total_out),
    .out_rate_kbps        (out_rate_kbps),
    .out_last_of_run      (out_last_of_run)
  );
endmodule

// File: sv/qtk_ram.sv
module qtk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/qtk_ctrl.sv
module qtk_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  qtk_pkg::stat_t stat,
  output qtk_pkg::cmd_t  cmd
);
  qtk_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qtk_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      qtk_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_nxt = qtk_pkg::ST_IDLE;
        end
      end
      qtk_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = qtk_pkg::ST_READ;
        end
      end
      qtk_pkg::ST_READ: begin
        cmd.div_start = 1'b1;
        state_nxt = qtk_pkg::ST_DIV;
      end
      qtk_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = qtk_pkg::ST_INSERT;
        end
      end
      qtk_pkg::ST_INSERT: begin
        cmd.insert = 1'b1;
        if (stat.item_last) begin
          cmd.emit_load = 1'b1;
          state_nxt = qtk_pkg::ST_EMIT;
        end else begin
          state_nxt = qtk_pkg::ST_IDLE;
        end
      end
      qtk_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_adv = 1'b1;
          if (stat.emit_last) begin
            cmd.list_clear = 1'b1;
            state_nxt = qtk_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = qtk_pkg::ST_IDLE;
    endcase
  end
endmodule

// File: sv/qtk_dp.sv
module qtk_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  qtk_pkg::cmd_t  cmd,
  output qtk_pkg::stat_t stat,
  input  logic [7:0]     in_queue_id,
  input  logic [63:0]    in_sent_byte_total,
  input  logic [31:0]    in_sent_packet_total,
  input  logic [31:0]    in_elapsed_ms,
  input  logic           in_round_end,
  output logic [3:0]     out_rank,
  output logic           out_slot_valid,
  output logic [7:0]     out_ranked_queue,
  output logic [63:0]    out_byte_delta,
  output logic [31:0]    out_packet_total_out,
  output logic [31:0]    out_rate_kbps,
  output logic           out_last_of_run
);
  localparam int N = qtk_pkg::TOP_COUNT;
  localparam int AW = qtk_pkg::QIDX_W;
  localparam int SW = qtk_pkg::SLOT_W;

  logic [7:0]  qid_r;
  logic [63:0] total_r;
  logic [31:0] pkts_r;
  logic [31:0] ms_r;
  logic        last_r;
  logic        in_range_r;
  logic [63:0] delta_r;
  logic [AW-1:0] clr_addr_r;
  logic [63:0] prev_rd;
  logic        ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0] ram_wdata;

  logic [66:0] quo_r;
  logic [32:0] rem_r;
  logic [6:0]  step_r;
  logic        rate_sat;
  logic [31:0] rate_val;
  logic [32:0] rem_sh;
  logic [33:0] rem_diff;

  logic [7:0]  tq_r [N];
  logic [63:0] td_r [N];
  logic [31:0] tp_r [N];
  logic [31:0] tr_r [N];
  logic [N-1:0] occ_r;
  logic [N-1:0] beats;
  logic [SW-1:0] emit_r;

  assign ram_we = cmd.clr_step | (cmd.div_start & in_range_r);
  assign ram_waddr = cmd.clr_step ? clr_addr_r : qid_r[AW-1:0];
  assign ram_wdata = cmd.clr_step ? 64'd0 : total_r;

  qtk_ram #(.WIDTH(64), .DEPTH(qtk_pkg::QUEUE_COUNT)) u_prev (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_queue_id[AW-1:0]),
    .rdata (prev_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      qid_r <= in_queue_id;
      total_r <= in_sent_byte_total;
      pkts_r <= in_sent_packet_total;
      ms_r <= in_elapsed_ms;
      last_r <= in_round_end;
      in_range_r <= (32'(in_queue_id) < 32'(qtk_pkg::QUEUE_COUNT));
    end
  end

  assign rem_sh = {rem_r[31:0], quo_r[66]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, ms_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      delta_r <= total_r - (in_range_r ? prev_rd : 64'd0);
      quo_r <= {3'b000, total_r - (in_range_r ? prev_rd : 64'd0)} << 3;
      rem_r <= '0;
      step_r <= '0;
    end else if (cmd.div_step && step_r != 7'(qtk_pkg::DIV_STEPS)) begin
      if (!rem_diff[33]) begin
        rem_r <= rem_diff[32:0];
        quo_r <= {quo_r[65:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[65:0], 1'b0};
      end
      step_r <= step_r + 7'd1;
    end
  end

  assign rate_sat = (ms_r == 32'd0) || (delta_r[63:61] != 3'b000) || (quo_r[66:32] != '0);
  assign rate_val = rate_sat ? qtk_pkg::RATE_MAX : quo_r[31:0];

  assign stat.div_done = (step_r == 7'(qtk_pkg::DIV_STEPS));
  assign stat.clr_done = (32'(clr_addr_r) == 32'(qtk_pkg::QUEUE_COUNT - 1));
  assign stat.item_last = last_r;
  assign stat.emit_last = (32'(emit_r) == 32'(N - 1));

  always_comb begin
    for (int j = 0; j < N; j++) begin
      beats[j] = !occ_r[j] || (td_r[j] < delta_r) ||
                 (td_r[j] == delta_r && tp_r[j] < pkts_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (cmd.list_clear) begin
      occ_r <= '0;
    end else if (cmd.insert) begin
      for (int k = 0; k < N; k++) begin
        if (beats[k] && (k == 0 || !beats[k-1 > 0 ? k-1 : 0] || k == 0)) begin
          occ_r[k] <= 1'b1;
        end else if (k > 0 && beats[k-1 > 0 ? k-1 : 0]) begin
          occ_r[k] <= occ_r[k-1 > 0 ? k-1 : 0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      for (int k = 0; k < N; k++) begin
        if (k > 0 && beats[k-1 > 0 ? k-1 : 0]) begin
          tq_r[k] <= tq_r[k-1 > 0 ? k-1 : 0];
          td_r[k] <= td_r[k-1 > 0 ? k-1 : 0];
          tp_r[k] <= tp_r[k-1 > 0 ? k-1 : 0];
          tr_r[k] <= tr_r[k-1 > 0 ? k-1 : 0];
        end else if (beats[k]) begin
          tq_r[k] <= qid_r;
          td_r[k] <= delta_r;
          tp_r[k] <= pkts_r;
          tr_r[k] <= rate_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r <= '0;
    end else if (cmd.emit_load) begin
      emit_r <= '0;
    end else if (cmd.emit_adv) begin
      emit_r <= stat.emit_last ? '0 : emit_r + SW'(1);
    end
  end

  always_comb begin
    out_rank = 4'(emit_r);
    out_slot_valid = 1'b0;
    out_ranked_queue = '0;
    out_byte_delta = '0;
    out_packet_total_out = '0;
    out_rate_kbps = '0;
    for (int j = 0; j < N; j++) begin
      if (32'(emit_r) == j && occ_r[j]) begin
        out_slot_valid = 1'b1;
        out_ranked_queue = tq_r[j];
        out_byte_delta = td_r[j];
        out_packet_total_out = tp_r[j];
        out_rate_kbps = tr_r[j];
      end
    end
    out_last_of_run = stat.emit_last;
  end
endmodule

// File: sv/qtk_checker.sv
`include "queue_throughput_top_k_core_defines.svh"
module qtk_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_rank,
  input logic       out_slot_valid,
  input logic [63:0] out_byte_delta,
  input logic       out_last_of_run
);
  `QTK_ASSERT_IMP(a_no_overlap, out_valid, !in_ready, "input taken during emission")
  `QTK_ASSERT_IMP(a_last_rank, out_valid, out_last_of_run == (out_rank == 4'd9), "last flag off rank")
  `QTK_ASSERT_NEXT(a_rank_step, out_valid && out_ready && !out_last_of_run, out_valid && out_rank == $past(out_rank) + 4'd1, "rank skipped")
  `QTK_ASSERT_IMP(a_empty_zero, out_valid && !out_slot_valid, out_byte_delta == 64'd0, "empty slot carries data")
  `QTK_ASSERT_NEXT(a_busy_after, in_valid && in_ready, !in_ready && !out_valid, "back to back accept")
endmodule

bind queue_throughput_top_k_core qtk_checker u_qtk_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_rank        (out_rank),
  .out_slot_valid  (out_slot_valid),
  .out_byte_delta  (out_byte_delta),
  .out_last_of_run (out_last_of_run)
);
